/* src/brl_pkg.sv */
// Package for the Bresenham line rasteriser: shared constants, opcode type
// and the structures passed between the setup, walker and top-level modules.
// No dependencies.
`default_nettype none

package brl_pkg;

    // Screen geometry and coordinate width
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int COORD_BITS    = 12;

    // Derived widths: differences need one extra bit, the error term two
    localparam int DELTA_W  = COORD_BITS + 1;
    localparam int ERR_W    = COORD_BITS + 2;
    localparam int ADDR_W   = 32;
    localparam int COLOUR_W = 16;

    // Row pitch in the frame buffer is 1 KiB, pixels are two bytes
    localparam int ADDR_Y_SHIFT = 10;
    localparam int ADDR_X_SHIFT = 1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Walk parameters worked out from a pair of endpoints
    typedef struct packed {
        logic                    steep;
        coord_t                  walk_major;
        coord_t                  walk_minor;
        coord_t                  major_end;
        logic [DELTA_W-1:0]      major_delta;
        logic [DELTA_W-1:0]      minor_delta;
        logic signed [ERR_W-1:0] error_term;
        logic signed [1:0]       minor_step;
    } setup_t;

    // One pixel as presented on the result channel
    typedef struct packed {
        logic                write_enable;
        coord_t              pixel_x;
        coord_t              pixel_y;
        logic [ADDR_W-1:0]   pixel_address;
        logic [COLOUR_W-1:0] pixel_colour;
        logic                last;
    } pixel_t;

endpackage

`default_nettype wire

/* src/brl_setup.sv */
// Line setup: orders the endpoints, picks the major axis and derives the
// deltas, initial error term and minor step. Purely combinational.
// Depends on brl_pkg.
`default_nettype none

module brl_setup
    import brl_pkg::*;
(
    input  wire coord_t start_x,
    input  wire coord_t start_y,
    input  wire coord_t end_x,
    input  wire coord_t end_y,
    output setup_t      setup
);

    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [DELTA_W-1:0]        abs_dx;
    logic [DELTA_W-1:0]        abs_dy;
    logic                      steep;
    coord_t                    a_maj, a_min, b_maj, b_min;
    coord_t                    p_maj, p_min, q_maj, q_min;
    logic signed [DELTA_W-1:0] maj_diff;
    logic signed [DELTA_W-1:0] min_diff;
    logic [DELTA_W-1:0]        abs_min;

    always_comb begin
        // steepness test on absolute differences
        dx     = {start_x[COORD_BITS-1], start_x} - {end_x[COORD_BITS-1], end_x};
        dy     = {start_y[COORD_BITS-1], start_y} - {end_y[COORD_BITS-1], end_y};
        abs_dx = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
        abs_dy = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
        steep  = abs_dy > abs_dx;

        // steep lines walk along y
        a_maj = steep ? start_y : start_x;
        a_min = steep ? start_x : start_y;
        b_maj = steep ? end_y   : end_x;
        b_min = steep ? end_x   : end_y;

        // order so that the major coordinate rises
        if (a_maj > b_maj) begin
            p_maj = b_maj;
            p_min = b_min;
            q_maj = a_maj;
            q_min = a_min;
        end else begin
            p_maj = a_maj;
            p_min = a_min;
            q_maj = b_maj;
            q_min = b_min;
        end

        maj_diff = {q_maj[COORD_BITS-1], q_maj} - {p_maj[COORD_BITS-1], p_maj};
        min_diff = {q_min[COORD_BITS-1], q_min} - {p_min[COORD_BITS-1], p_min};
        abs_min  = min_diff[DELTA_W-1] ? DELTA_W'(-min_diff) : DELTA_W'(min_diff);

        setup.steep       = steep;
        setup.walk_major  = p_maj;
        setup.walk_minor  = p_min;
        setup.major_end   = q_maj;
        setup.major_delta = DELTA_W'(maj_diff);
        setup.minor_delta = abs_min;
        setup.error_term  = -$signed({1'b0, DELTA_W'(maj_diff) >> 1});
        if (min_diff > 0) begin
            setup.minor_step = 2'sb01;
        end else if (min_diff < 0) begin
            setup.minor_step = 2'sb11;
        end else begin
            setup.minor_step = 2'sb00;
        end
    end

endmodule

`default_nettype wire

/* src/brl_walker.sv */
// Bresenham walk state: holds the current line, advances one pixel per
// step and presents the current pixel with its on-screen flag and address.
// Depends on brl_pkg.
`default_nettype none

module brl_walker
    import brl_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 load_en,
    input  wire                 step_en,
    input  wire setup_t         setup,
    input  wire [COLOUR_W-1:0]  load_colour,
    input  wire [ADDR_W-1:0]    frame_base,
    output pixel_t              pixel
);

    logic                    active_reg, active_next;
    logic                    steep_reg, steep_next;
    coord_t                  walk_major_reg, walk_major_next;
    coord_t                  walk_minor_reg, walk_minor_next;
    coord_t                  major_end_reg, major_end_next;
    logic [DELTA_W-1:0]      major_delta_reg, major_delta_next;
    logic [DELTA_W-1:0]      minor_delta_reg, minor_delta_next;
    logic signed [ERR_W-1:0] error_term_reg, error_term_next;
    logic signed [1:0]       minor_step_reg, minor_step_next;
    logic [COLOUR_W-1:0]     held_colour_reg, held_colour_next;

    logic signed [ERR_W-1:0] err_sum;
    logic                    fin;
    coord_t                  px, py;
    logic [ADDR_W-1:0]       x_off, y_off;
    logic                    on_screen;

    // current pixel
    always_comb begin
        px    = steep_reg ? walk_minor_reg : walk_major_reg;
        py    = steep_reg ? walk_major_reg : walk_minor_reg;
        fin   = walk_major_reg >= major_end_reg;
        x_off = ADDR_W'(signed'(px)) << ADDR_X_SHIFT;
        y_off = ADDR_W'(signed'(py)) << ADDR_Y_SHIFT;
        on_screen = !px[COORD_BITS-1] && !py[COORD_BITS-1]
                 && ({{(32-COORD_BITS){1'b0}}, px} < 32'(SCREEN_WIDTH))
                 && ({{(32-COORD_BITS){1'b0}}, py} < 32'(SCREEN_HEIGHT));

        if (active_reg) begin
            pixel.write_enable  = on_screen;
            pixel.pixel_x       = px;
            pixel.pixel_y       = py;
            pixel.pixel_address = frame_base + y_off + x_off;
            pixel.pixel_colour  = held_colour_reg;
            pixel.last          = fin;
        end else begin
            pixel = '0;
        end
    end

    // next walk state
    always_comb begin
        active_next      = active_reg;
        steep_next       = steep_reg;
        walk_major_next  = walk_major_reg;
        walk_minor_next  = walk_minor_reg;
        major_end_next   = major_end_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        error_term_next  = error_term_reg;
        minor_step_next  = minor_step_reg;
        held_colour_next = held_colour_reg;
        err_sum = error_term_reg + $signed({1'b0, minor_delta_reg});

        if (load_en) begin
            active_next      = 1'b1;
            steep_next       = setup.steep;
            walk_major_next  = setup.walk_major;
            walk_minor_next  = setup.walk_minor;
            major_end_next   = setup.major_end;
            major_delta_next = setup.major_delta;
            minor_delta_next = setup.minor_delta;
            error_term_next  = setup.error_term;
            minor_step_next  = setup.minor_step;
            held_colour_next = load_colour;
        end else if (step_en && active_reg) begin
            if (err_sum >= 0) begin
                walk_minor_next = walk_minor_reg
                                + {{(COORD_BITS-2){minor_step_reg[1]}}, minor_step_reg};
                error_term_next = err_sum - $signed({1'b0, major_delta_reg});
            end else begin
                error_term_next = err_sum;
            end
            if (fin) begin
                active_next = 1'b0;
            end else begin
                walk_major_next = walk_major_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            steep_reg       <= 1'b0;
            walk_major_reg  <= '0;
            walk_minor_reg  <= '0;
            major_end_reg   <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            error_term_reg  <= '0;
            minor_step_reg  <= '0;
            held_colour_reg <= '0;
        end else begin
            active_reg      <= active_next;
            steep_reg       <= steep_next;
            walk_major_reg  <= walk_major_next;
            walk_minor_reg  <= walk_minor_next;
            major_end_reg   <= major_end_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            error_term_reg  <= error_term_next;
            minor_step_reg  <= minor_step_next;
            held_colour_reg <= held_colour_next;
        end
    end

`ifndef SYNTHESIS
    // a live walk never runs past its end point
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> walk_major_reg <= major_end_reg)
        else $error("walker passed its end point");

    // the error term never goes positive between steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        error_term_reg <= 0)
        else $error("error term out of range");

    // the major axis is always the longer one
    assert property (@(posedge aclk) disable iff (!aresetn)
        minor_delta_reg <= major_delta_reg)
        else $error("minor delta exceeds major delta");

    // the last pixel of a line ends the walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !load_en && active_reg && fin) |=> !active_reg)
        else $error("walk did not stop after its last pixel");
`endif

endmodule

`default_nettype wire

/* src/bresenham_line_rasterizer.sv */
// Bresenham line rasteriser top level: stream handshake, frame base
// register and result register around the setup and walker logic.
// Depends on brl_pkg, brl_setup and brl_walker.
//
// Usage:
//   The input stream carries one word per command. s_tuser selects the
//   command: a load word latches two endpoints and a colour and gives no
//   result; a step word emits the next pixel of the line on the output
//   stream. The last pixel of a line carries m_tlast, after which the
//   engine is idle; a step while idle returns an all-zero word. m_tuser is
//   the write enable, low for pixels off screen.
//   frame_base is written through cfg_wr_en/cfg_wr_data while idle.
// Timing:
//   A step word's pixel appears on the output in the cycle after it is taken.
//   One word is taken every cycle unless the receiver stalls; the walk update
//   steps the error term, and a single output register holds the finished pixel.
//   If the receiver stalls with a pixel held, s_tready drops until that
//   pixel is taken; it stays high when the register drains in that cycle.
// Reset:
//   aresetn (synchronous, active low) clears the line state, the frame base
//   and the output valid.
`default_nettype none

module bresenham_line_rasterizer
    import brl_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         cfg_wr_en,
    input  wire [31:0]  cfg_wr_data,    // frame_base
    // command stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [63:0]  s_tdata,        // start_x, start_y, end_x, end_y, line_colour
    input  wire         s_tuser,        // opcode
    // pixel stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,        // pixel_x, pixel_y, pixel_address, pixel_colour
    output logic        m_tuser,        // write_enable
    output logic        m_tlast         // last
);

    logic [ADDR_W-1:0] frame_base_reg;
    logic              m_valid_reg, m_valid_next;
    pixel_t            m_pixel_reg;
    logic              s_accept;
    opcode_t           opcode;
    logic              load_en, step_en;
    setup_t            setup;
    pixel_t            pixel;

    assign opcode   = opcode_t'(s_tuser);
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign load_en  = s_accept && (opcode == OP_LOAD);
    assign step_en  = s_accept && (opcode == OP_STEP);

    brl_setup u_setup (
        .start_x (s_tdata[11:0]),
        .start_y (s_tdata[23:12]),
        .end_x   (s_tdata[35:24]),
        .end_y   (s_tdata[47:36]),
        .setup   (setup)
    );

    brl_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_en     (load_en),
        .step_en     (step_en),
        .setup       (setup),
        .load_colour (s_tdata[63:48]),
        .frame_base  (frame_base_reg),
        .pixel       (pixel)
    );

    // frame base register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= '0;
        end else if (cfg_wr_en) begin
            frame_base_reg <= cfg_wr_data;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (step_en) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_pixel_reg <= pixel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_pixel_reg.write_enable;
    assign m_tlast  = m_pixel_reg.last;
    assign m_tdata  = {m_pixel_reg.pixel_colour, m_pixel_reg.pixel_address,
                       m_pixel_reg.pixel_y, m_pixel_reg.pixel_x};

`ifndef SYNTHESIS
    // a load word never produces a pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_LOAD && m_tready) |=> !m_tvalid)
        else $error("load produced a pixel");

    // every step word produces a pixel in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_STEP) |=> m_tvalid)
        else $error("step produced no pixel");

    // an enabled write always has non-negative coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (!m_tdata[11] && !m_tdata[23]))
        else $error("write enabled for a negative coordinate");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for bresenham_line_rasterizer: queues load and step words,
// predicts each pixel word on acceptance and checks the pixel stream field by field.
// Depends on brl_pkg and the rasteriser RTL; reads no files.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import brl_pkg::*;

    localparam int STALL_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int SETTLE      = 4;      // a load gives no result, so allow it to land

    // one command word as queued for the driver
    typedef struct {
        opcode_t     op;
        coord_t      ax, ay, bx, by;
        logic [15:0] rgb;
    } cmd_t;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [31:0]  cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata     = '0;      // start_x, start_y, end_x, end_y, line_colour
    logic         s_tuser     = 1'b0;    // opcode
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [71:0]  m_tdata;               // pixel_x, pixel_y, pixel_address, pixel_colour
    logic         m_tuser;               // write_enable
    logic         m_tlast;               // last

    bresenham_line_rasterizer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    cmd_t   cmd_queue[$];
    pixel_t pending_pixels[$];
    cmd_t   in_flight;

    // shadow of the line engine
    logic              line_live  = 1'b0;
    logic              shadow_steep = 1'b0;
    coord_t            cur_major  = '0;
    coord_t            cur_minor  = '0;
    coord_t            end_major  = '0;
    logic [12:0]       run_len    = '0;
    logic [12:0]       rise_len   = '0;
    logic signed [13:0] err_acc   = '0;
    logic signed [1:0] minor_dir  = '0;
    logic [15:0]       line_rgb   = '0;
    logic [31:0]       frame_base_q = '0;

    bit quiet = 1'b0;      // no idling on either side while set
    int tx_gap = 0;
    int rx_hold = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int loads_taken = 0, steps_taken = 0, base_writes = 0;
    int pixels_seen = 0, on_screen = 0, line_ends = 0;

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // predict the effect of one accepted word
    task automatic advance_line(input cmd_t c);
        int ax, ay, bx, by, t, px, py, acc;
        logic fin;
        pixel_t p;
        if (c.op == OP_LOAD) begin
            ax = c.ax; ay = c.ay; bx = c.bx; by = c.by;
            shadow_steep = iabs(ay - by) > iabs(ax - bx);
            if (shadow_steep) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            run_len   = 13'(bx - ax);
            rise_len  = 13'(iabs(by - ay));
            err_acc   = 14'(-((bx - ax) >>> 1));
            minor_dir = (by > ay) ? 2'sb01 : ((by < ay) ? 2'sb11 : 2'sb00);
            cur_major = 12'(ax);
            cur_minor = 12'(ay);
            end_major = 12'(bx);
            line_rgb  = c.rgb;
            line_live = 1'b1;
            loads_taken++;
        end else begin
            steps_taken++;
            if (!line_live) begin
                // step with no line loaded: all-zero word
                p = '0;
            end else begin
                px = shadow_steep ? cur_minor : cur_major;
                py = shadow_steep ? cur_major : cur_minor;
                fin = cur_major >= end_major;
                p.write_enable  = px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT;
                p.pixel_x       = 12'(px);
                p.pixel_y       = 12'(py);
                p.pixel_address = frame_base_q + (32'(py) << ADDR_Y_SHIFT)
                                  + (32'(px) << ADDR_X_SHIFT);
                p.pixel_colour  = line_rgb;
                p.last          = fin;
                // error update happens on the final pixel as well
                acc = int'(err_acc) + int'(rise_len);
                if (acc >= 0) begin
                    cur_minor = cur_minor + minor_dir;
                    acc = acc - int'(run_len);
                end
                err_acc = 14'(acc);
                if (fin) line_live = 1'b0;
                else cur_major = cur_major + 12'sd1;
            end
            pending_pixels.push_back(p);
        end
    endtask

    // driver: one word offered at a time, a gap drawn as each word is offered and waited out after it is taken
    always @(posedge aclk) begin
        cmd_t nxt;
        logic free;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            free = !s_tvalid;
            if (s_tvalid && s_tready) begin
                advance_line(in_flight);
                free = 1'b1;
            end
            if (free) begin
                if (tx_gap > 0 || cmd_queue.size() == 0) begin
                    if (tx_gap > 0) tx_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = cmd_queue.pop_front();
                    in_flight = nxt;
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= {nxt.rgb, nxt.by, nxt.bx, nxt.ay, nxt.ax};
                    tx_gap = pick_gap();
                end
            end
        end
    end

    // monitor: compare each pixel word with the oldest prediction
    always @(posedge aclk) begin
        pixel_t got, want;
        logic bad;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.write_enable  = m_tuser;
                got.pixel_x       = m_tdata[11:0];
                got.pixel_y       = m_tdata[23:12];
                got.pixel_address = m_tdata[55:24];
                got.pixel_colour  = m_tdata[71:56];
                got.last          = m_tlast;
                pixels_seen++;
                if (got.write_enable) on_screen++;
                if (got.last) line_ends++;
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel word x=%0d y=%0d addr=%h",
                                 got.pixel_x, got.pixel_y, got.pixel_address);
                end else begin
                    want = pending_pixels.pop_front();
                    bad = (want.write_enable  != got.write_enable)
                        | (want.pixel_x       != got.pixel_x)
                        | (want.pixel_y       != got.pixel_y)
                        | (want.pixel_address != got.pixel_address)
                        | (want.pixel_colour  != got.pixel_colour)
                        | (want.last          != got.last);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("pixel %0d expected we=%0b x=%0d y=%0d addr=%h rgb=%h last=%0b",
                                     pixels_seen, want.write_enable, want.pixel_x, want.pixel_y,
                                     want.pixel_address, want.pixel_colour, want.last);
                            $display("pixel %0d got      we=%0b x=%0d y=%0d addr=%h rgb=%h last=%0b",
                                     pixels_seen, got.write_enable, got.pixel_x, got.pixel_y,
                                     got.pixel_address, got.pixel_colour, got.last);
                        end
                    end
                end
            end
            // receiver back-pressure
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_hold = pick_gap();
            end
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_load(input int ax, ay, bx, by, input logic [15:0] rgb);
        cmd_t c;
        c.op = OP_LOAD;
        c.ax = 12'(ax); c.ay = 12'(ay); c.bx = 12'(bx); c.by = 12'(by);
        c.rgb = rgb;
        cmd_queue.push_back(c);
    endtask

    // step words carry random filler in the unused fields
    task automatic queue_steps(input int n);
        cmd_t c;
        repeat (n) begin
            c.op = OP_STEP;
            c.ax = 12'($urandom); c.ay = 12'($urandom);
            c.bx = 12'($urandom); c.by = 12'($urandom);
            c.rgb = 16'($urandom);
            cmd_queue.push_back(c);
        end
    endtask

    function automatic int any_coord();
        coord_t v;
        v = 12'($urandom);
        return v;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    // mostly whole short lines near the screen, some cut short, some with random ends and step counts, or stray steps
    task automatic queue_random_words(input int budget);
        int added, r, ax, ay, bx, by, len, n;
        added = 0;
        while (added < budget) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                queue_steps(1);
                added++;
            end else begin
                if (r < 8) begin
                    ax = any_coord(); ay = any_coord();
                    bx = any_coord(); by = any_coord();
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        ax = any_coord(); ay = any_coord();
                    end else begin
                        ax = int'($urandom_range(0, 360)) - 20;
                        ay = int'($urandom_range(0, 280)) - 20;
                    end
                    bx = clamp_coord(ax + int'($urandom_range(0, 30)) - 15);
                    by = clamp_coord(ay + int'($urandom_range(0, 30)) - 15);
                end
                len = ((iabs(bx - ax) > iabs(by - ay)) ? iabs(bx - ax) : iabs(by - ay)) + 1;
                if (r < 8)
                    n = $urandom_range(1, 30);
                else if (r < 15)
                    n = $urandom_range(0, len - 1);
                else
                    n = len;
                queue_load(ax, ay, bx, by, 16'($urandom));
                queue_steps(n);
                added += n + 1;
            end
        end
    endtask

    // wait for all words to be taken and all pixels returned
    task automatic drain();
        @(negedge aclk);
        while (cmd_queue.size() != 0 || s_tvalid || pending_pixels.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_base(input logic [31:0] value);
        drain();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        frame_base_q = value;
        base_writes++;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle step, single point, replaced line, steep, screen edge, falling y
        queue_steps(1);
        queue_load(5, 7, 5, 7, 16'hFFFF);
        queue_steps(2);
        queue_load(-2048, 2047, 2047, -2048, 16'h0000);
        queue_steps(2);
        queue_load(3, 0, 1, 4, 16'h1234);
        queue_steps(5);
        queue_load(319, 239, 320, 240, 16'hA5A5);
        queue_steps(2);
        queue_load(0, 3, 4, 0, 16'h5A5A);
        queue_steps(5);

        write_base(32'hFFFF_FFFF);
        queue_random_words(150);

        write_base(32'h0000_0000);
        quiet = 1'b1;
        queue_random_words(100);

        write_base($urandom);
        quiet = 1'b0;
        queue_random_words(200);

        write_base(32'h8000_0000);
        queue_random_words(150);

        drain();
        repeat (10) @(posedge aclk);

        $display("covered %0d load words and %0d step words over %0d frame base settings",
                 loads_taken, steps_taken, base_writes + 1);
        $display("checked %0d pixel words: %0d on screen, %0d line ends, %0d mismatched",
                 pixels_seen, on_screen, line_ends, mismatches);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
